[sv/quaternion_slerp_top_defines.svh]
// Assertion macros used by the checker file of the blend unit.
`ifndef QUATERNION_SLERP_TOP_DEFINES_SVH
`define QUATERNION_SLERP_TOP_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define QS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent, outside reset.
`define QS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Same as the next-cycle form, but also checked while reset is high.
`define QS_ASSERT_ALWAYS_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[sv/qslerp_pkg.sv]
package qslerp_pkg;

  localparam int CW = 34;
  localparam int WQ = 31;
  localparam int SQ_STEPS = 31;
  localparam int TABLE_LEN = 30;
  localparam logic [15:0] THR_RESET = 16'd3277;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [WQ-1:0] ONE_30 = 31'd1073741824;

  typedef logic signed [CW-1:0] cword_t;
  typedef logic [WQ-1:0] weight_t;

  function automatic cword_t atan_q30(input int unsigned idx);
    cword_t r;
    case (idx)
      0: r = 34'sd843314857;
      1: r = 34'sd497837829;
      2: r = 34'sd263043837;
      3: r = 34'sd133525159;
      4: r = 34'sd67021687;
      5: r = 34'sd33543514;
      6: r = 34'sd16775851;
      7: r = 34'sd8388437;
      8: r = 34'sd4194283;
      9: r = 34'sd2097149;
      10: r = 34'sd1048576;
      11: r = 34'sd524288;
      12: r = 34'sd262144;
      13: r = 34'sd131072;
      14: r = 34'sd65536;
      15: r = 34'sd32768;
      16: r = 34'sd16384;
      17: r = 34'sd8192;
      18: r = 34'sd4096;
      19: r = 34'sd2048;
      20: r = 34'sd1024;
      21: r = 34'sd512;
      22: r = 34'sd256;
      23: r = 34'sd128;
      24: r = 34'sd64;
      25: r = 34'sd32;
      26: r = 34'sd16;
      27: r = 34'sd8;
      28: r = 34'sd4;
      29: r = 34'sd2;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

endpackage

[sv/qslerp_ifs.sv]
interface qslerp_req_if #(parameter int W = 16);
  logic valid;
  logic ready;
  logic signed [W-1:0] src_x;
  logic signed [W-1:0] src_y;
  logic signed [W-1:0] src_z;
  logic signed [W-1:0] src_w;
  logic signed [W-1:0] dst_x;
  logic signed [W-1:0] dst_y;
  logic signed [W-1:0] dst_z;
  logic signed [W-1:0] dst_w;
  logic [W-1:0] blend;
  modport source(output valid, src_x, src_y, src_z, src_w, dst_x, dst_y, dst_z, dst_w,
                 blend, input ready);
  modport sink(input valid, src_x, src_y, src_z, src_w, dst_x, dst_y, dst_z, dst_w,
               blend, output ready);
endinterface

interface qslerp_rsp_if #(parameter int W = 16);
  logic valid;
  logic ready;
  logic signed [W-1:0] out_x;
  logic signed [W-1:0] out_y;
  logic signed [W-1:0] out_z;
  logic signed [W-1:0] out_w;
  modport source(output valid, out_x, out_y, out_z, out_w, input ready);
  modport sink(input valid, out_x, out_y, out_z, out_w, output ready);
endinterface

interface qslerp_cfg_if;
  logic valid;
  logic ready;
  logic [15:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

[sv/quaternion_slerp_top.sv]
// Quaternion spherical blend unit, fully pipelined.
// Input channel req carries a source quaternion, a target quaternion and
// the blend factor; a transfer happens when valid and ready are both high.
// Output channel rsp returns one blended quaternion per input transfer, in
// order. The cfg channel writes the linear threshold and is always ready.
// From input to output transfer the path runs through the square root
// (31 steps), the arc cosine CORDIC, the sine CORDICs and the weight
// dividers (31 steps), one stage per step.
// Throughput is one item per cycle unless the receiver stalls: four lanes
// form the products and final blends; the angle path is one deep pipeline.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and req.ready drops; as soon as the result is taken the next input is
// accepted in the same cycle. Reset clears all pending items and sets the
// threshold to 3277 (0.1 in Q1.15).
module quaternion_slerp_top import qslerp_pkg::*; #(
  parameter int COMPONENT_BITS = 16,
  parameter int ANGLE_ITERATIONS = 16
) (
  input logic          clk,
  input logic          rst,
  qslerp_cfg_if.sink   cfg,
  qslerp_req_if.sink   req,
  qslerp_rsp_if.source rsp
);

  localparam int W = COMPONENT_BITS;
  localparam int F = W - 1;
  localparam int N = ANGLE_ITERATIONS;
  localparam int L = 68 + 2*N;
  localparam int DLY = 32 + N;
  localparam int SW = 8*W + 4 + 2*WQ + 1;
  localparam int UPSH = (F <= 30) ? 30 - F : 0;
  localparam int DNSH = (F > 30) ? F - 30 : 0;
  localparam int TUP = (F >= 15) ? F - 15 : 0;
  localparam int TDN = (F < 15) ? 15 - F : 0;
  localparam logic [W-1:0] ONE_F = {1'b1, {F{1'b0}}};
  localparam logic [61:0] ONE_60 = 62'(1) << 60;

  logic          en;
  logic [L-1:0]  vld;
  logic [15:0]   lt;

  logic signed [W-1:0] src_in [4];
  logic signed [W-1:0] dst_in [4];
  logic signed [W:0]   prod1  [4];
  logic signed [W-1:0] src1   [4];
  logic signed [W-1:0] dst1   [4];
  logic [W-1:0]        t1;

  logic signed [W+2:0] cos_sum;
  logic signed [W+2:0] cos_abs;
  logic [W-1:0]        t_cl;
  logic [W-1:0]        c_cl;
  logic [63:0]         thr;
  logic signed [63:0]  margin;
  weight_t             t30;
  logic [SW-1:0]       side_next;
  logic [SW-1:0]       side2;
  logic [WQ-1:0]       c30_2;

  logic [61:0]   csq;
  logic [60:0]   sq3;
  logic [30:0]   sqrt_y;
  logic [WQ-1:0] c30_d;
  cword_t        om;
  logic [SW-1:0] side_a;
  logic [SW-1:0] side_b;
  weight_t       w1a;
  logic signed [CW+WQ:0] a1_prod;
  cword_t        om_r;
  cword_t        a1_r;
  cword_t        sinom;
  cword_t        sin0;
  cword_t        sin1;
  weight_t       q0;
  weight_t       q1;
  cword_t        d_out;
  logic          use_s;
  weight_t       w0_sel;
  weight_t       w1_sel;
  logic signed [W-1:0] src_b [4];
  logic signed [W:0]   tgt_b [4];
  logic signed [W-1:0] res   [4];

  assign en        = !vld[L-1] || rsp.ready;
  assign req.ready = en;
  assign rsp.valid = vld[L-1];
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lt  <= THR_RESET;
      vld <= '0;
    end else begin
      if (cfg.valid) begin
        lt <= cfg.data;
      end
      if (en) begin
        vld <= {vld[L-2:0], req.valid};
      end
    end
  end

  assign src_in[0] = req.src_x;
  assign src_in[1] = req.src_y;
  assign src_in[2] = req.src_z;
  assign src_in[3] = req.src_w;
  assign dst_in[0] = req.dst_x;
  assign dst_in[1] = req.dst_y;
  assign dst_in[2] = req.dst_z;
  assign dst_in[3] = req.dst_w;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        src1[k] <= src_in[k];
        dst1[k] <= dst_in[k];
      end
      t1 <= req.blend;
    end
  end

  always_comb begin
    cos_sum = '0;
    for (int k = 0; k < 4; k++) begin
      cos_sum = cos_sum + (W+3)'(prod1[k]);
    end
    cos_abs = cos_sum[W+2] ? -cos_sum : cos_sum;
    t_cl    = (t1 > ONE_F) ? ONE_F : t1;
    c_cl    = ($unsigned(cos_abs) > (W+3)'(ONE_F)) ? ONE_F : cos_abs[W-1:0];
    t30     = WQ'((64'(t_cl) << UPSH) >> DNSH);
    thr     = (64'(lt) << TUP) >> TDN;
    margin  = $signed(64'(ONE_F)) - 64'(cos_abs);
    for (int k = 0; k < 4; k++) begin
      side_next[k*W +: W] = src1[k];
      side_next[4*W + k*(W+1) +: W+1] =
          cos_sum[W+2] ? -(W+1)'(dst1[k]) : (W+1)'(dst1[k]);
    end
    side_next[8*W+4 +: WQ]      = t30;
    side_next[8*W+4+WQ +: WQ]   = ONE_30 - t30;
    side_next[SW-1]             = margin > $signed(thr);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side2 <= side_next;
      c30_2 <= WQ'((64'(c_cl) << UPSH) >> DNSH);
      sq3   <= 61'(ONE_60 - csq);
    end
  end

  assign csq = 62'(c30_2) * 62'(c30_2);

  qslerp_isqrt u_sqrt (
    .clk (clk),
    .en  (en),
    .v   (sq3),
    .r   (sqrt_y)
  );

  qslerp_delay #(.WD(WQ), .DEPTH(SQ_STEPS + 1)) u_c30_dly (
    .clk (clk),
    .en  (en),
    .d   (c30_2),
    .q   (c30_d)
  );

  qslerp_cordic #(.ITER(N), .VECT(1'b1)) u_acos (
    .clk   (clk),
    .en    (en),
    .x0    (cword_t'(c30_d)),
    .y0    (cword_t'(sqrt_y)),
    .z0    ('0),
    .y_out (),
    .z_out (om)
  );

  qslerp_delay #(.WD(SW), .DEPTH(DLY)) u_side_a (
    .clk (clk),
    .en  (en),
    .d   (side2),
    .q   (side_a)
  );

  assign w1a     = side_a[8*W+4 +: WQ];
  assign a1_prod = om * $signed({1'b0, w1a});

  always_ff @(posedge clk) begin
    if (en) begin
      om_r <= om;
      a1_r <= CW'(a1_prod >>> 30);
    end
  end

  qslerp_delay #(.WD(SW), .DEPTH(DLY)) u_side_b (
    .clk (clk),
    .en  (en),
    .d   (side_a),
    .q   (side_b)
  );

  qslerp_cordic #(.ITER(N), .VECT(1'b0)) u_sin_om (
    .clk   (clk),
    .en    (en),
    .x0    (CORDIC_GAIN),
    .y0    ('0),
    .z0    (om_r),
    .y_out (sinom),
    .z_out ()
  );

  qslerp_cordic #(.ITER(N), .VECT(1'b0)) u_sin_0 (
    .clk   (clk),
    .en    (en),
    .x0    (CORDIC_GAIN),
    .y0    ('0),
    .z0    (om_r - a1_r),
    .y_out (sin0),
    .z_out ()
  );

  qslerp_cordic #(.ITER(N), .VECT(1'b0)) u_sin_1 (
    .clk   (clk),
    .en    (en),
    .x0    (CORDIC_GAIN),
    .y0    ('0),
    .z0    (a1_r),
    .y_out (sin1),
    .z_out ()
  );

  qslerp_div u_div_0 (
    .clk   (clk),
    .en    (en),
    .s     (sin0),
    .d     (sinom),
    .q     (q0),
    .d_out (d_out)
  );

  qslerp_div u_div_1 (
    .clk   (clk),
    .en    (en),
    .s     (sin1),
    .d     (sinom),
    .q     (q1),
    .d_out ()
  );

  assign use_s  = side_b[SW-1] && (d_out > 0);
  assign w0_sel = use_s ? q0 : side_b[8*W+4+WQ +: WQ];
  assign w1_sel = use_s ? q1 : side_b[8*W+4 +: WQ];

  for (genvar k = 0; k < 4; k++) begin : g_lane
    assign src_b[k] = $signed(side_b[k*W +: W]);
    assign tgt_b[k] = $signed(side_b[4*W + k*(W+1) +: W+1]);
    qslerp_lane #(.W(W)) u_lane (
      .clk  (clk),
      .en   (en),
      .a    (src_in[k]),
      .b    (dst_in[k]),
      .prod (prod1[k]),
      .w0   (w0_sel),
      .w1   (w1_sel),
      .src  (src_b[k]),
      .tgt  (tgt_b[k]),
      .res  (res[k])
    );
  end

  assign rsp.out_x = res[0];
  assign rsp.out_y = res[1];
  assign rsp.out_z = res[2];
  assign rsp.out_w = res[3];

endmodule

[sv/qslerp_delay.sv]
module qslerp_delay #(
  parameter int WD = 8,
  parameter int DEPTH = 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [WD-1:0] d,
  output logic [WD-1:0] q
);

  logic [WD-1:0] sr [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        sr[i] <= sr[i-1];
      end
    end
  end

  assign q = sr[DEPTH-1];

endmodule

[sv/qslerp_lane.sv]
module qslerp_lane import qslerp_pkg::*; #(
  parameter int W = 16
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  output logic signed [W:0]   prod,
  input  weight_t             w0,
  input  weight_t             w1,
  input  logic signed [W-1:0] src,
  input  logic signed [W:0]   tgt,
  output logic signed [W-1:0] res
);

  localparam int F = W - 1;
  localparam logic signed [W+3:0] MAXV = (W+4)'((64'sd1 <<< F) - 64'sd1);
  localparam logic signed [W+3:0] MINV = -MAXV - (W+4)'(1);
  localparam logic signed [W+33:0] ROUND = (W+34)'(64'sd1 <<< 29);

  logic signed [2*W-1:0] ab;
  logic signed [W+31:0]  m0;
  logic signed [W+32:0]  m1;
  logic signed [W+32:0]  m0r;
  logic signed [W+32:0]  m1r;
  logic signed [W+33:0]  sum;
  logic signed [W+3:0]   rr;

  assign ab  = a * b;
  assign m0  = $signed({1'b0, w0}) * src;
  assign m1  = $signed({1'b0, w1}) * tgt;
  assign sum = (W+34)'(m0r) + (W+34)'(m1r) + ROUND;
  assign rr  = sum[W+33:30];

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= ab[2*W-1:F];
      m0r  <= (W+33)'(m0);
      m1r  <= m1;
      if (rr > MAXV) begin
        res <= MAXV[W-1:0];
      end else if (rr < MINV) begin
        res <= MINV[W-1:0];
      end else begin
        res <= rr[W-1:0];
      end
    end
  end

endmodule

[sv/qslerp_isqrt.sv]
module qslerp_isqrt import qslerp_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [60:0] v,
  output logic [30:0] r
);

  logic [61:0] vs [SQ_STEPS];
  logic [61:0] rs [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    localparam logic [61:0] B = 62'(1) << (60 - 2*k);
    logic [61:0] vp;
    logic [61:0] rp;
    logic [61:0] trial;
    if (k == 0) begin : g_first
      assign vp = 62'(v);
      assign rp = '0;
    end else begin : g_rest
      assign vp = vs[k-1];
      assign rp = rs[k-1];
    end
    assign trial = rp + B;
    always_ff @(posedge clk) begin
      if (en) begin
        if (vp >= trial) begin
          vs[k] <= vp - trial;
          rs[k] <= (rp >> 1) + B;
        end else begin
          vs[k] <= vp;
          rs[k] <= rp >> 1;
        end
      end
    end
  end

  assign r = rs[SQ_STEPS-1][30:0];

endmodule

[sv/qslerp_cordic.sv]
module qslerp_cordic import qslerp_pkg::*; #(
  parameter int ITER = 16,
  parameter bit VECT = 1'b0
) (
  input  logic   clk,
  input  logic   en,
  input  cword_t x0,
  input  cword_t y0,
  input  cword_t z0,
  output cword_t y_out,
  output cword_t z_out
);

  cword_t xs [ITER];
  cword_t ys [ITER];
  cword_t zs [ITER];

  for (genvar i = 0; i < ITER; i++) begin : g_it
    cword_t xp, yp, zp, dx, dy;
    logic pos;
    if (i == 0) begin : g_first
      assign xp = x0;
      assign yp = y0;
      assign zp = z0;
    end else begin : g_rest
      assign xp = xs[i-1];
      assign yp = ys[i-1];
      assign zp = zs[i-1];
    end
    assign dx  = yp >>> i;
    assign dy  = xp >>> i;
    assign pos = VECT ? !(yp > 0) : (zp >= 0);
    always_ff @(posedge clk) begin
      if (en) begin
        if (pos) begin
          xs[i] <= xp - dx;
          ys[i] <= yp + dy;
          zs[i] <= zp - atan_q30(i);
        end else begin
          xs[i] <= xp + dx;
          ys[i] <= yp - dy;
          zs[i] <= zp + atan_q30(i);
        end
      end
    end
  end

  assign y_out = ys[ITER-1];
  assign z_out = zs[ITER-1];

endmodule

[sv/qslerp_div.sv]
module qslerp_div import qslerp_pkg::*; (
  input  logic    clk,
  input  logic    en,
  input  cword_t  s,
  input  cword_t  d,
  output weight_t q,
  output cword_t  d_out
);

  logic [CW-1:0] rem [WQ];
  cword_t        dd  [WQ];
  weight_t       qq  [WQ];
  logic          zf  [WQ];
  logic          bf  [WQ];

  logic zero0;
  logic big0;

  assign zero0 = (s <= 0);
  assign big0  = $signed({s[CW-1], s}) >= $signed({d, 1'b0});

  for (genvar j = 0; j < WQ; j++) begin : g_bit
    logic [CW-1:0] rp;
    cword_t        dp;
    weight_t       qp;
    logic          zp;
    logic          bp;
    logic          ge;
    logic [CW-1:0] nr;
    if (j == 0) begin : g_first
      assign rp = s;
      assign dp = d;
      assign qp = '0;
      assign zp = zero0;
      assign bp = big0;
    end else begin : g_rest
      assign rp = rem[j-1];
      assign dp = dd[j-1];
      assign qp = qq[j-1];
      assign zp = zf[j-1];
      assign bp = bf[j-1];
    end
    assign ge = rp >= $unsigned(dp);
    assign nr = ge ? rp - $unsigned(dp) : rp;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j] <= nr << 1;
        dd[j]  <= dp;
        qq[j]  <= qp | (WQ'(ge) << (WQ - 1 - j));
        zf[j]  <= zp;
        bf[j]  <= bp;
      end
    end
  end

  always_comb begin
    if (zf[WQ-1]) begin
      q = '0;
    end else if (bf[WQ-1] || qq[WQ-1] > ONE_30) begin
      q = ONE_30;
    end else begin
      q = qq[WQ-1];
    end
  end

  assign d_out = dd[WQ-1];

endmodule

[sv/qslerp_check.sv]
`include "quaternion_slerp_top_defines.svh"

module qslerp_check #(
  parameter int W = 16
) (
  input logic         clk,
  input logic         rst,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input logic [W-1:0] out_x
);

  // A waiting result stays offered until its transfer.
  `QS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `QS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_x), "result changed while stalled")
  // The input side only stalls while a result is held back.
  `QS_ASSERT_IMPL(a_in_ready, !out_valid || out_ready, in_ready, "input stalled without cause")
  `QS_ASSERT_ALWAYS_NEXT(a_reset, rst, !out_valid, "result offered after reset")

endmodule

bind quaternion_slerp_top qslerp_check #(.W(COMPONENT_BITS)) u_qslerp_check (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (req.ready),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .out_x     (rsp.out_x)
);
